FILE: hdl/tcsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell score accumulator package
// Shared sizes, word types, control structs and depth helpers.
// ----------------------------------------------------------------------------
package tcsa_pkg;

  localparam int MAX_DEPTH      = 3;
  localparam int RESPONSE_WIDTH = 32;
  localparam int SUM_WIDTH      = 48;

  localparam int DEPTH_W      = 2;
  localparam int CELL_W       = MAX_DEPTH;
  localparam int BUCKET_W     = CELL_W + 1;
  localparam int CELL_COUNT   = 1 << MAX_DEPTH;
  localparam int BUCKET_COUNT = 2 * CELL_COUNT;

  // Input word: one sample
  typedef struct packed {
    logic                             treated;
    logic [CELL_W-1:0]                cut_bits;
    logic signed [RESPONSE_WIDTH-1:0] weighted_response;
    logic                             last_sample;
  } sample_t;

  // Output word: one cell result
  typedef struct packed {
    logic [CELL_W-1:0]           cell_res;
    logic signed [SUM_WIDTH-1:0] score;
    logic                        last_cell;
  } result_t;

  // Shared read port request
  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
  } rd_req_t;

  // Accumulator write-back
  typedef struct packed {
    logic                 en;
    logic                 treated;
    logic [CELL_W-1:0]    addr;
    logic [SUM_WIDTH-1:0] data;
  } acc_wr_t;

  // Run end: kick off the readout
  typedef struct packed {
    logic              start;
    logic [CELL_W-1:0] last_idx;
  } drain_start_t;

  // Readout status toward the bucket store
  typedef struct packed {
    logic busy;
    logic clr;
  } drain_ctl_t;

  // Map the depth register to the depth in force (zero acts as one)
  function automatic logic [DEPTH_W-1:0] active_depth(input logic [DEPTH_W-1:0] cfg);
    logic [DEPTH_W-1:0] d;
    d = cfg;
    if (d == '0) d = DEPTH_W'(1);
    if (d > DEPTH_W'(MAX_DEPTH)) d = DEPTH_W'(MAX_DEPTH);
    return d;
  endfunction

  // Mask of the cut bits that a depth uses, also the last cell index
  function automatic logic [CELL_W-1:0] cell_mask(input logic [DEPTH_W-1:0] depth);
    logic [CELL_W:0] full;
    full = ({{CELL_W{1'b0}}, 1'b1} << depth) - 1'b1;
    return full[CELL_W-1:0];
  endfunction

endpackage

FILE: hdl/treatment_cell_score_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Treatment cell score accumulator
// Sums weighted responses per (cell, treatment) bucket and emits one
// treated-minus-untreated score per cell at the end of each run.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one sample
//   word per cycle while a run accumulates. Each word does a read-modify-
//   write of one bucket in the two bucket RAMs (treated and untreated side);
//   back-to-back hits on one bucket are forwarded from the write-back.
//   The word flagged last_sample ends the run: input stalls for that word's
//   write-back cycle and then for the readout, one read of both RAMs per
//   cell, 2^depth cells. The first result follows the last word through the
//   stage-one register, the readout state, the RAM read register and the
//   output register; then one result per cycle unless the output stalls.
//   Output channel (out_valid_o / out_stall_i / out_word_o) is registered;
//   a receiver stall holds the word and pauses the readout, and new samples
//   are taken again once the last cell's data sits in the output register.
//   cfg_we_i / cfg_wdata_i write the search depth (reset value 1).
//   Reset clears the per-bucket valid flags, so all sums read as zero; the
//   final readout of each run clears them the same way, with no sweep.
// ----------------------------------------------------------------------------
module treatment_cell_score_accumulator import tcsa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [DEPTH_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sample_t            in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output result_t            out_word_o
);

  logic [DEPTH_W-1:0]      depth_q;
  logic [CELL_W-1:0]       cut_mask;
  logic [BUCKET_COUNT-1:0] vld_q;
  logic [SUM_WIDTH-1:0]    rdata_t;
  logic [SUM_WIDTH-1:0]    rdata_u;
  rd_req_t                 acc_rd;
  rd_req_t                 drn_rd;
  acc_wr_t                 acc_wr;
  drain_start_t            start;
  drain_ctl_t              drn_ctl;
  logic                    rd_en;
  logic [CELL_W-1:0]       rd_addr;

  // Depth register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_W'(1);
    end else if (cfg_we_i) begin
      depth_q <= cfg_wdata_i;
    end
  end

  assign cut_mask = cell_mask(active_depth(depth_q));

  // Bucket valid flags: set on write-back, drop all on the final readout
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (drn_ctl.clr) begin
      vld_q <= '0;
    end else if (acc_wr.en) begin
      vld_q[{acc_wr.addr, acc_wr.treated}] <= 1'b1;
    end
  end

  // Share the read port between accumulate and readout
  assign rd_en   = acc_rd.en | drn_rd.en;
  assign rd_addr = drn_rd.en ? drn_rd.addr : acc_rd.addr;

  tcsa_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (CELL_COUNT)
  ) u_ram_treated (
    .clk_i   (clk_i),
    .we_i    (acc_wr.en & acc_wr.treated),
    .waddr_i (acc_wr.addr),
    .wdata_i (acc_wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata_t)
  );

  tcsa_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (CELL_COUNT)
  ) u_ram_untreated (
    .clk_i   (clk_i),
    .we_i    (acc_wr.en & ~acc_wr.treated),
    .waddr_i (acc_wr.addr),
    .wdata_i (acc_wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata_u)
  );

  tcsa_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .cut_mask_i   (cut_mask),
    .hold_i       (drn_ctl.busy),
    .bucket_vld_i (vld_q),
    .rdata_t_i    (rdata_t),
    .rdata_u_i    (rdata_u),
    .rd_o         (acc_rd),
    .wr_o         (acc_wr),
    .start_o      (start)
  );

  tcsa_drain u_drain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .bucket_vld_i (vld_q),
    .rdata_t_i    (rdata_t),
    .rdata_u_i    (rdata_u),
    .rd_o         (drn_rd),
    .ctl_o        (drn_ctl),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

  // No sample enters while the readout owns the RAMs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drn_ctl.busy |-> !(in_valid_i && !in_stall_o))
    else $error("sample accepted during readout");

  // Accumulate and readout never share the read port in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc_rd.en && drn_rd.en))
    else $error("read port conflict");

  // Clearing never collides with a bucket write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(drn_ctl.clr && acc_wr.en))
    else $error("clear during write-back");

  // Run end always starts the readout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start.start |=> drn_ctl.busy)
    else $error("readout did not start");

endmodule

FILE: hdl/tcsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module tcsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tcsa_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample accumulate pipeline
// Read the bucket on accept, add the response in the next cycle, write back.
// ----------------------------------------------------------------------------
module tcsa_accum import tcsa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sample_t                  in_word_i,
  input  logic [CELL_W-1:0]        cut_mask_i,
  input  logic                     hold_i,
  input  logic [BUCKET_COUNT-1:0]  bucket_vld_i,
  input  logic [SUM_WIDTH-1:0]     rdata_t_i,
  input  logic [SUM_WIDTH-1:0]     rdata_u_i,
  output rd_req_t                  rd_o,
  output acc_wr_t                  wr_o,
  output drain_start_t             start_o
);

  logic                      accept;
  logic [CELL_W-1:0]         cut;
  logic                      s1_valid_q;
  logic [BUCKET_W-1:0]       s1_bucket_q;
  logic [RESPONSE_WIDTH-1:0] s1_resp_q;
  logic                      s1_last_q;
  logic [CELL_W-1:0]         s1_last_idx_q;
  logic                      wb_valid_q;
  logic [BUCKET_W-1:0]       wb_bucket_q;
  logic [SUM_WIDTH-1:0]      wb_data_q;
  logic [SUM_WIDTH-1:0]      base;
  logic [SUM_WIDTH-1:0]      resp_ext;
  logic [SUM_WIDTH-1:0]      sum;

  // Hold input while a readout runs or the run's last word is in flight
  assign in_stall_o = hold_i | (s1_valid_q & s1_last_q);
  assign accept     = in_valid_i & ~in_stall_o;
  assign cut        = in_word_i.cut_bits & cut_mask_i;

  // Issue the bucket read on accept (both sides share the address)
  assign rd_o.en   = accept;
  assign rd_o.addr = cut;

  // Stage one control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      wb_valid_q <= s1_valid_q;
    end
  end

  // Stage one payload and last write-back for forwarding
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bucket_q   <= {cut, in_word_i.treated};
      s1_resp_q     <= in_word_i.weighted_response;
      s1_last_q     <= in_word_i.last_sample;
      s1_last_idx_q <= cut_mask_i;
    end
    wb_bucket_q <= s1_bucket_q;
    wb_data_q   <= sum;
  end

  // Pick the old sum: forward the previous write, else RAM data or zero if unwritten
  always_comb begin
    if (wb_valid_q && (wb_bucket_q == s1_bucket_q)) begin
      base = wb_data_q;
    end else if (bucket_vld_i[s1_bucket_q]) begin
      base = s1_bucket_q[0] ? rdata_t_i : rdata_u_i;
    end else begin
      base = '0;
    end
  end

  assign resp_ext = {{(SUM_WIDTH-RESPONSE_WIDTH){s1_resp_q[RESPONSE_WIDTH-1]}}, s1_resp_q};
  assign sum      = base + resp_ext;

  // Write back the new sum
  assign wr_o.en      = s1_valid_q;
  assign wr_o.treated = s1_bucket_q[0];
  assign wr_o.addr    = s1_bucket_q[BUCKET_W-1:1];
  assign wr_o.data    = sum;

  // Start the readout once the last word's sum is being written
  assign start_o.start    = s1_valid_q & s1_last_q;
  assign start_o.last_idx = s1_last_idx_q;

endmodule

FILE: hdl/tcsa_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell readout
// Read both sides of each cell, subtract, and hand results to the output
// register; clear the buckets with the final read.
// ----------------------------------------------------------------------------
module tcsa_drain import tcsa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  drain_start_t            start_i,
  input  logic [BUCKET_COUNT-1:0] bucket_vld_i,
  input  logic [SUM_WIDTH-1:0]    rdata_t_i,
  input  logic [SUM_WIDTH-1:0]    rdata_u_i,
  output rd_req_t                 rd_o,
  output drain_ctl_t              ctl_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output result_t                 out_word_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_q;
  logic [CELL_W-1:0] cnt_q;
  logic [CELL_W-1:0] last_idx_q;
  logic              done_issue_q;
  logic              rdv_q;
  logic [CELL_W-1:0] rd_cell_q;
  logic              rd_last_q;
  logic [1:0]        rd_mask_q;
  logic              out_valid_q;
  result_t           out_word_q;
  logic              issue;
  logic              move;
  logic              issue_last;
  logic [SUM_WIDTH-1:0] treated_sum;
  logic [SUM_WIDTH-1:0] untreated_sum;

  // Move read data into the output register when it is free or draining
  assign move       = rdv_q & (~out_valid_q | ~out_stall_i);
  assign issue      = (state_q == ST_RUN) & ~done_issue_q & (~rdv_q | move);
  assign issue_last = issue & (cnt_q == last_idx_q);

  assign rd_o.en   = issue;
  assign rd_o.addr = cnt_q;
  assign ctl_o.busy = (state_q == ST_RUN);
  assign ctl_o.clr  = issue_last;

  // Sequence the cell reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      done_issue_q <= 1'b0;
      rdv_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i.start) begin
            state_q      <= ST_RUN;
            cnt_q        <= '0;
            done_issue_q <= 1'b0;
          end
        end
        ST_RUN: begin
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
            if (issue_last) begin
              done_issue_q <= 1'b1;
            end
          end
          if (move && rd_last_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (issue) begin
        rdv_q <= 1'b1;
      end else if (move) begin
        rdv_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch the run length and per-read cell tags
  always_ff @(posedge clk_i) begin
    if (start_i.start && (state_q == ST_IDLE)) begin
      last_idx_q <= start_i.last_idx;
    end
    if (issue) begin
      rd_cell_q <= cnt_q;
      rd_last_q <= issue_last;
      rd_mask_q <= {bucket_vld_i[{cnt_q, 1'b1}], bucket_vld_i[{cnt_q, 1'b0}]};
    end
    if (move) begin
      out_word_q.cell_res  <= rd_cell_q;
      out_word_q.score     <= treated_sum - untreated_sum;
      out_word_q.last_cell <= rd_last_q;
    end
  end

  // Unwritten buckets read as zero
  assign treated_sum   = rd_mask_q[1] ? rdata_t_i : '0;
  assign untreated_sum = rd_mask_q[0] ? rdata_u_i : '0;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell score accumulator testbench
// Drives sample words through the input channel while the output channel
// stalls at random, and predicts every cell score from a local copy of the
// bucket sums and the search depth. A short table of directed words covers
// the reset depth, response extremes, ignored cut bits, depth zero and depth
// changes inside a run; random runs of samples follow.
// ----------------------------------------------------------------------------
module testbench;
  import tcsa_pkg::*;

  localparam int RANDOM_WORDS = 208;
  localparam int SETTLE_CYCLES = 4;

  // Typed-in scores for a depth-one run, used instead of the prediction
  typedef struct packed {
    logic                        typed;
    logic signed [SUM_WIDTH-1:0] cell0;
    logic signed [SUM_WIDTH-1:0] cell1;
  } golden_t;

  typedef struct {
    bit           set_depth;
    logic [1:0]   depth;
    sample_t      word;
    golden_t      gold;
  } step_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [DEPTH_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  sample_t            in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  result_t            out_word_o;

  // Local copy of the block state
  logic [DEPTH_W-1:0]   depth_model = DEPTH_W'(1);
  logic [SUM_WIDTH-1:0] bucket_sum [BUCKET_COUNT];

  result_t   cell_score_q [$];
  golden_t   typed_scores_q [$];
  step_row_t directed_plan [$];
  int        mismatch_count = 0;
  bit        quiet_phase = 1'b0;

  treatment_cell_score_accumulator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  // Add one sample into its bucket; on the last sample emit the cell scores
  task automatic accumulate_sample(input sample_t w, input golden_t g);
    logic [DEPTH_W-1:0] d;
    int                 cells;
    logic [CELL_W-1:0]  cut;
    logic [BUCKET_W-1:0] slot;
    result_t            r;
    d = depth_model;
    if (d == '0) d = DEPTH_W'(1);
    if (d > DEPTH_W'(MAX_DEPTH)) d = DEPTH_W'(MAX_DEPTH);
    cells = 1 << d;
    cut = w.cut_bits & CELL_W'(cells - 1);
    slot = {cut, w.treated};
    bucket_sum[slot] = bucket_sum[slot] +
      {{(SUM_WIDTH - RESPONSE_WIDTH){w.weighted_response[RESPONSE_WIDTH-1]}},
       w.weighted_response};
    if (!w.last_sample) return;
    for (int j = 0; j < cells; j++) begin
      r.cell_res  = CELL_W'(j);
      r.score     = bucket_sum[2 * j + 1] - bucket_sum[2 * j];
      r.last_cell = (j == cells - 1);
      if (g.typed) r.score = (j == 0) ? g.cell0 : g.cell1;
      cell_score_q.insert(cell_score_q.size(), r);
    end
    foreach (bucket_sum[k]) bucket_sum[k] = '0;
  endtask

  function automatic step_row_t mk_step(bit set_d, logic [1:0] d, logic t, logic [2:0] c,
                                        logic [31:0] resp, logic last, logic typed = 1'b0,
                                        logic signed [SUM_WIDTH-1:0] s0 = '0,
                                        logic signed [SUM_WIDTH-1:0] s1 = '0);
    step_row_t r;
    r.set_depth              = set_d;
    r.depth                  = d;
    r.word.treated           = t;
    r.word.cut_bits          = c;
    r.word.weighted_response = resp;
    r.word.last_sample       = last;
    r.gold.typed             = typed;
    r.gold.cell0             = s0;
    r.gold.cell1             = s1;
    return r;
  endfunction

  // Append one row to the directed table
  task automatic add_row(input step_row_t r);
    directed_plan.insert(directed_plan.size(), r);
  endtask

  // Drive one word, idling at random beforehand, and hold it until taken
  task automatic push_sample(input sample_t w);
    if (!quiet_phase) begin
      while ($urandom_range(99) < 23) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop sending and wait until every expected score has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (cell_score_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_depth(input logic [DEPTH_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    foreach (bucket_sum[k]) bucket_sum[k] = '0;
  end

  // Stall the output side at random outside the quiet stretch
  always @(posedge clk_i) begin
    out_stall_i <= !quiet_phase && ($urandom_range(99) < 23);
  end

  // Predict on every taken sample word and check every taken result word
  always @(posedge clk_i) begin
    golden_t g;
    result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        g = '0;
        if (typed_scores_q.size() != 0) g = typed_scores_q.pop_front();
        accumulate_sample(in_word_i, g);
      end
      if (out_valid_o && !out_stall_i) begin
        if (cell_score_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word for cell %0d",
                                    out_word_o.cell_res));
        end else begin
          want = cell_score_q.pop_front();
          if (out_word_o.cell_res !== want.cell_res)
            report_mismatch($sformatf("cell_res got %0d want %0d",
                                      out_word_o.cell_res, want.cell_res));
          if (out_word_o.score !== want.score)
            report_mismatch($sformatf("cell %0d score got %0d want %0d",
                                      want.cell_res, out_word_o.score, want.score));
          if (out_word_o.last_cell !== want.last_cell)
            report_mismatch($sformatf("cell %0d last_cell got %0b want %0b",
                                      want.cell_res, out_word_o.last_cell, want.last_cell));
        end
      end
      if (cfg_we_i) depth_model = cfg_wdata_i;
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sample_t w;
    int      sent;
    int      run_len;
    int      pick;
    bit      held;

    // Reset depth, response extremes and ignored cut bits at depth one
    add_row(mk_step(0, 0, 1, 0, 32'h0001_0000, 1, 1, 48'sd65536, 0));
    add_row(mk_step(0, 0, 1, 1, 32'h7FFF_FFFF, 0));
    add_row(mk_step(0, 0, 0, 1, 32'h8000_0000, 1, 1, 0, 48'sd4294967295));
    add_row(mk_step(0, 0, 0, 3'b110, 32'hFFFF_FFFF, 1, 1, 48'sd1, 0));
    // Depth zero acts as depth one; repeated hits on one bucket
    add_row(mk_step(1, 0, 1, 3'b111, 32'h8000_0000, 1, 1, 0,
                    -48'sd2147483648));
    add_row(mk_step(0, 0, 1, 0, 32'h7FFF_FFFF, 0));
    add_row(mk_step(0, 0, 1, 0, 32'h7FFF_FFFF, 0));
    add_row(mk_step(0, 0, 0, 0, 32'h8000_0000, 1, 1, 48'sd6442450942, 0));
    // Full depth, all eight cells
    add_row(mk_step(1, 3, 1, 7, 32'h7FFF_FFFF, 0));
    add_row(mk_step(0, 0, 0, 7, 32'h7FFF_FFFF, 0));
    add_row(mk_step(0, 0, 1, 5, 32'h1234_5678, 0));
    add_row(mk_step(0, 0, 0, 2, 32'hFFFF_0000, 0));
    add_row(mk_step(0, 0, 1, 0, 32'h8000_0000, 0));
    add_row(mk_step(0, 0, 0, 3, 32'h0000_8000, 1));
    // Depth two with the top cut bit ignored
    add_row(mk_step(1, 2, 1, 3'b111, 32'h7FFF_FFFF, 0));
    add_row(mk_step(0, 0, 0, 3'b100, 32'h8000_0000, 0));
    add_row(mk_step(0, 0, 1, 2, 32'h0000_0005, 1));
    // Depth drops inside a run, then rises inside a run
    add_row(mk_step(1, 3, 1, 6, 32'h0000_0064, 0));
    add_row(mk_step(0, 0, 0, 1, 32'h0000_00C8, 0));
    add_row(mk_step(1, 1, 1, 1, 32'h4000_0000, 1));
    add_row(mk_step(0, 0, 0, 7, 32'h7FFF_FFFF, 0));
    add_row(mk_step(1, 3, 1, 7, 32'hFFFF_FFFB, 1));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_plan[k]) begin
      if (directed_plan[k].set_depth) begin
        wait_drained();
        write_depth(directed_plan[k].depth);
      end
      typed_scores_q.insert(typed_scores_q.size(), directed_plan[k].gold);
      push_sample(directed_plan[k].word);
    end

    // Random runs, each closed by a last word
    sent = 0;
    held = 1'b0;
    w    = '0;
    while (sent < RANDOM_WORDS) begin
      quiet_phase <= (sent >= 90 && sent < 150);
      if (!held && sent >= 60) begin
        held = 1'b1;
        wait_drained();
      end
      if ($urandom_range(3) == 0) begin
        wait_drained();
        write_depth(DEPTH_W'($urandom_range(3)));
      end
      run_len = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
      for (int i = 0; i < run_len; i++) begin
        if (i > 0 && $urandom_range(11) == 0) begin
          wait_drained();
          write_depth(DEPTH_W'($urandom_range(3)));
        end
        // In about three words of ten, keep the bucket of the previous word to hit forwarding
        if (i == 0 || $urandom_range(9) > 2) begin
          w.treated  = 1'($urandom_range(1));
          w.cut_bits = CELL_W'($urandom_range(7));
        end
        pick = $urandom_range(9);
        case (pick)
          0: w.weighted_response = 32'h7FFF_FFFF;
          1: w.weighted_response = 32'h8000_0000;
          2: w.weighted_response = 32'($urandom_range(512)) - 32'd256;
          default: w.weighted_response = $urandom;
        endcase
        w.last_sample = (i == run_len - 1);
        push_sample(w);
        sent++;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && cell_score_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
